FILE: rtl/core/dcl_pkg.sv
// Shared types and constants for the deadband change logger.
// Holds the register map, reset values and the structs passed between modules.
// No dependencies.
`default_nettype none
package dcl_pkg;

	localparam int NUM_TEMPS = 6;
	localparam int TIME_W = 32;
	localparam int TEMP_W = 16;
	localparam int ACT_W = 4;
	localparam int THR_W = 12;
	localparam int IVL_W = 16;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [THR_W-1:0] RST_DELTA_THRESHOLD = 12'd2;
	localparam logic [IVL_W-1:0] RST_MIN_INTERVAL = 16'd60;
	localparam logic [IVL_W-1:0] RST_MAX_INTERVAL = 16'd600;
	localparam logic [TIME_W-1:0] RST_VALID_TIME_FLOOR = 32'd1704067200;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DELTA_THRESHOLD = 2'd0,
		REG_MIN_INTERVAL = 2'd1,
		REG_MAX_INTERVAL = 2'd2,
		REG_VALID_TIME_FLOOR = 2'd3
	} reg_idx_t;

	typedef logic [NUM_TEMPS-1:0][TEMP_W-1:0] temp_vec_t;

	typedef struct packed {
		logic [THR_W-1:0] delta_threshold;
		logic [IVL_W-1:0] min_interval;
		logic [IVL_W-1:0] max_interval;
		logic [TIME_W-1:0] valid_time_floor;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] now;
		temp_vec_t temps;
		logic [ACT_W-1:0] actors;
	} snap_t;

	// Last recorded snapshot; has_rec is clear until the first record.
	typedef struct packed {
		logic has_rec;
		logic [TIME_W-1:0] rec_time;
		temp_vec_t temps;
		logic [ACT_W-1:0] actors;
	} base_t;

	typedef struct packed {
		logic in_window;
		logic changed;
		logic emit;
	} decision_t;

endpackage
`default_nettype wire

FILE: rtl/core/dcl_cfg_regs.sv
// Configuration register file of the deadband change logger.
// Uses dcl_pkg for the register map and reset values.
`default_nettype none
module dcl_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [dcl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [dcl_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output dcl_pkg::cfg_t                            cfg
);

	dcl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_threshold <= dcl_pkg::RST_DELTA_THRESHOLD;
			cfg_q.min_interval <= dcl_pkg::RST_MIN_INTERVAL;
			cfg_q.max_interval <= dcl_pkg::RST_MAX_INTERVAL;
			cfg_q.valid_time_floor <= dcl_pkg::RST_VALID_TIME_FLOOR;
		end else if (cfg_we) begin
			unique case (dcl_pkg::reg_idx_t'(cfg_index))
				dcl_pkg::REG_DELTA_THRESHOLD:
					cfg_q.delta_threshold <= cfg_wdata[dcl_pkg::THR_W-1:0];
				dcl_pkg::REG_MIN_INTERVAL:
					cfg_q.min_interval <= cfg_wdata[dcl_pkg::IVL_W-1:0];
				dcl_pkg::REG_MAX_INTERVAL:
					cfg_q.max_interval <= cfg_wdata[dcl_pkg::IVL_W-1:0];
				dcl_pkg::REG_VALID_TIME_FLOOR:
					cfg_q.valid_time_floor <= cfg_wdata[dcl_pkg::TIME_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

FILE: rtl/core/dcl_decide.sv
// Record decision of the deadband change logger: six deadband compares,
// an actuator compare, the interval checks and the valid-time check. Uses dcl_pkg types.
`default_nettype none
module dcl_decide (
	input  wire dcl_pkg::cfg_t  cfg,
	input  wire dcl_pkg::snap_t snap,
	input  wire dcl_pkg::base_t base,
	output dcl_pkg::decision_t  dec
);

	localparam int DIFF_W = dcl_pkg::TEMP_W + 1;

	logic [dcl_pkg::NUM_TEMPS-1:0] big;
	logic [dcl_pkg::TIME_W-1:0]    elapsed;
	logic                          past_min;
	logic                          past_max;

	for (genvar i = 0; i < dcl_pkg::NUM_TEMPS; i++) begin : g_temp
		logic signed [DIFF_W-1:0] diff;
		logic [DIFF_W-1:0]        mag;

		assign diff = $signed({snap.temps[i][dcl_pkg::TEMP_W-1], snap.temps[i]})
			- $signed({base.temps[i][dcl_pkg::TEMP_W-1], base.temps[i]});
		// The magnitude of a 17-bit difference of two 16-bit values fits unsigned.
		assign mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
		assign big[i] = mag >= DIFF_W'(cfg.delta_threshold);
	end

	// Unsigned wrap makes a backward clock look like a long gap.
	assign elapsed = snap.now - base.rec_time;
	assign past_min = elapsed >= dcl_pkg::TIME_W'(cfg.min_interval);
	assign past_max = elapsed >= dcl_pkg::TIME_W'(cfg.max_interval);

	always_comb begin
		dec.in_window = snap.now >= cfg.valid_time_floor;
		dec.changed = (|big) || (snap.actors != base.actors);
		dec.emit = dec.in_window
			&& (!base.has_rec || past_max || (past_min && dec.changed));
	end

endmodule
`default_nettype wire

FILE: rtl/core/deadband_change_logger.sv
// Deadband change logger: a snapshot is recorded when the clock is valid and
// either nothing was recorded yet, the maximum interval has passed, or a
// significant change appears after the minimum interval.
// A record is registered in the first stage at its input transfer and then in the output stage;
// one snapshot is taken every cycle while the output side keeps up.
// Reset restores the register defaults and clears the recorded reference.
`default_nettype none
module deadband_change_logger (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [dcl_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [dcl_pkg::CFG_DATA_W-1:0]         cfg_wdata,
	input  wire logic                                   in_valid,
	output      logic                                   in_ready,
	input  wire logic [dcl_pkg::TIME_W-1:0]             now_seconds,
	input  wire logic signed [dcl_pkg::TEMP_W-1:0]      roof_tenths,
	input  wire logic signed [dcl_pkg::TEMP_W-1:0]      boiler_tenths,
	input  wire logic signed [dcl_pkg::TEMP_W-1:0]      storage_tenths,
	input  wire logic signed [dcl_pkg::TEMP_W-1:0]      return_tenths,
	input  wire logic signed [dcl_pkg::TEMP_W-1:0]      pool_tenths,
	input  wire logic signed [dcl_pkg::TEMP_W-1:0]      pool_target_tenths,
	input  wire logic [dcl_pkg::ACT_W-1:0]              actor_bits,
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic [dcl_pkg::TIME_W-1:0]             rec_seconds,
	output      logic signed [dcl_pkg::TEMP_W-1:0]      rec_roof,
	output      logic signed [dcl_pkg::TEMP_W-1:0]      rec_boiler,
	output      logic signed [dcl_pkg::TEMP_W-1:0]      rec_storage,
	output      logic signed [dcl_pkg::TEMP_W-1:0]      rec_return,
	output      logic signed [dcl_pkg::TEMP_W-1:0]      rec_pool,
	output      logic signed [dcl_pkg::TEMP_W-1:0]      rec_pool_target,
	output      logic [dcl_pkg::ACT_W-1:0]              rec_actors
);

	dcl_pkg::cfg_t      cfg;
	dcl_pkg::snap_t     snap_in;
	dcl_pkg::snap_t     snap_s1;
	dcl_pkg::snap_t     snap_s2;
	dcl_pkg::base_t     base_q;
	dcl_pkg::decision_t dec;
	logic               valid_s1;
	logic               valid_s2;
	logic               adv_s1;
	logic               load_s2;

	dcl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_comb begin
		snap_in.now = now_seconds;
		snap_in.temps = {pool_target_tenths, pool_tenths, return_tenths,
			storage_tenths, boiler_tenths, roof_tenths};
		snap_in.actors = actor_bits;
	end

	dcl_decide u_decide (
		.cfg  (cfg),
		.snap (snap_s1),
		.base (base_q),
		.dec  (dec)
	);

	// The first stage moves on whenever the output slot is free or drains this
	// cycle; a snapshot that is not recorded is simply dropped.
	assign adv_s1 = !valid_s2 || out_ready;
	assign load_s2 = valid_s1 && adv_s1 && dec.emit;
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			snap_s1 <= snap_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= load_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			snap_s2 <= snap_s1;
		end
	end

	// The reference moves with the record, so the next snapshot in the first
	// stage already compares against it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (load_s2) begin
			base_q.has_rec <= 1'b1;
			base_q.rec_time <= snap_s1.now;
			base_q.temps <= snap_s1.temps;
			base_q.actors <= snap_s1.actors;
		end
	end

	assign out_valid = valid_s2;
	assign rec_seconds = snap_s2.now;
	assign rec_roof = snap_s2.temps[0];
	assign rec_boiler = snap_s2.temps[1];
	assign rec_storage = snap_s2.temps[2];
	assign rec_return = snap_s2.temps[3];
	assign rec_pool = snap_s2.temps[4];
	assign rec_pool_target = snap_s2.temps[5];
	assign rec_actors = snap_s2.actors;

`ifndef NO_ASSERTIONS
	a_has_rec_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		base_q.has_rec |=> base_q.has_rec)
		else $error("reference lost its recorded flag");

	a_base_tracks_record: assert property (@(posedge clk) disable iff (!arst_n)
		load_s2 |=> (out_valid && base_q.rec_time == rec_seconds
			&& base_q.actors == rec_actors))
		else $error("reference does not match the record just loaded");

	a_free_slot_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while the output slot is empty");

	a_record_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> base_q.has_rec)
		else $error("record shown without a recorded reference");
`endif

endmodule
`default_nettype wire
